### rtl/kpseg_pkg.sv
// Shared types and constants for the keypad scanner and segment display latch.
package kpseg_pkg;

  // Widths fixed by the block's register and result fields.
  localparam int TICK_W    = 24;
  localparam int SEG_W     = 8;
  localparam int KEY_IDX_W = 4;
  // Row numbers travel at the width that the largest supported keypad needs.
  localparam int ROW_IDX_W = 3;

  typedef logic [ROW_IDX_W-1:0] row_idx_t;

  // Decode request from the scan sequencer to the display latch.
  typedef struct packed {
    logic     accept;
    row_idx_t row;
  } decode_req_t;

endpackage

### rtl/kpseg_scan.sv
// Debounce and row scan sequencer for the keypad scanner.
module kpseg_scan #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [COLUMNS-1:0]               cols,
  input  logic [kpseg_pkg::TICK_W-1:0]     debounce_ticks,
  output logic [ROWS-1:0]                  drive_next,
  output kpseg_pkg::decode_req_t           decode,
  output logic [COLUMNS-1:0]               saved_cols
);

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_SCAN = 2'd2;

  logic [1:0]                   phase, phase_next;
  logic [COLUMNS-1:0]           prev_cols, saved_cols_next;
  logic [kpseg_pkg::TICK_W-1:0] wait_count, wait_count_next;
  logic [ROW_W-1:0]             probe_row, probe_row_next;
  logic [ROW_W-1:0]             probe_inc;

  assign probe_inc = probe_row + ROW_W'(1);

  always_comb begin
    phase_next      = phase;
    saved_cols_next = saved_cols;
    wait_count_next = wait_count;
    probe_row_next  = probe_row;
    drive_next      = '0;
    decode.accept   = 1'b0;
    decode.row      = kpseg_pkg::row_idx_t'(probe_row);
    unique case (phase)
      PH_WAIT: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - kpseg_pkg::TICK_W'(1);
        end else if (cols == saved_cols) begin
          phase_next     = PH_SCAN;
          probe_row_next = '0;
          drive_next     = ROWS'(1);
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_SCAN: begin
        if (&cols) begin
          // The row driven last tick released every column: that is the key's row.
          decode.accept = 1'b1;
          phase_next    = PH_IDLE;
        end else if (probe_row == ROW_W'(ROWS - 1)) begin
          // No row answered, so fall back to row zero.
          decode.accept = 1'b1;
          decode.row    = '0;
          phase_next    = PH_IDLE;
        end else begin
          probe_row_next = probe_inc;
          drive_next     = ROWS'(1) << probe_inc;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (|(prev_cols & ~cols)) begin
          saved_cols_next = cols;
          wait_count_next = debounce_ticks;
          phase_next      = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      prev_cols  <= '1;
      saved_cols <= '1;
      wait_count <= '0;
      probe_row  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      prev_cols  <= cols;
      saved_cols <= saved_cols_next;
      wait_count <= wait_count_next;
      probe_row  <= probe_row_next;
    end
  end

endmodule

### rtl/kpseg_display.sv
// Key index decode, segment lookup and display latch.
module kpseg_display #(
  parameter int COLUMNS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  kpseg_pkg::decode_req_t            decode,
  input  logic [COLUMNS-1:0]                saved_cols,
  output logic [kpseg_pkg::SEG_W-1:0]       shown_pattern,
  output logic [kpseg_pkg::KEY_IDX_W-1:0]   shown_key
);

  localparam int KEY_W     = 7;
  localparam int SEG_COUNT = 12;

  localparam logic [kpseg_pkg::SEG_W-1:0] SEG_TABLE [SEG_COUNT] = '{
    8'h06, 8'h5B, 8'h4F,
    8'h66, 8'h6D, 8'h7D,
    8'h07, 8'h7F, 8'h67,
    8'h77, 8'h3F, 8'h7C
  };

  logic [2:0]                    col;
  logic [KEY_W-1:0]              key;
  logic [kpseg_pkg::SEG_W-1:0]   pattern;

  // The pressed column is the lowest one that read low; column zero if none did.
  always_comb begin
    logic found;
    found = 1'b0;
    col   = '0;
    for (int i = 0; i < COLUMNS; i++) begin
      if (!found && !saved_cols[i]) begin
        col   = 3'(i);
        found = 1'b1;
      end
    end
  end

  assign key = KEY_W'(COLUMNS) * KEY_W'(decode.row) + KEY_W'(col);

  always_comb begin
    if (key < KEY_W'(SEG_COUNT)) begin
      pattern = SEG_TABLE[key[3:0]];
    end else begin
      pattern = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_pattern <= '0;
      shown_key     <= '0;
    end else if (step && decode.accept) begin
      shown_pattern <= pattern;
      shown_key     <= key[kpseg_pkg::KEY_IDX_W-1:0];
    end
  end

endmodule

### rtl/matrix_keypad_scan_to_segments.sv
// Keypad scanner top level: input stage, sequencer, display latch and result stage.
// Path: an item is taken into the input register and then moves into the result register;
//   one item per cycle while out_stall is low, since output backpressure holds the input register.
// The scan sequencer advances once per item, so debounce and row timing count items.
// Reset (synchronous, rst high) empties both stages, idles the sequencer, sets the
//   saved column levels to all ones, clears the display latch and loads 600000 ticks.
module matrix_keypad_scan_to_segments #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  // Column sample items.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [COLUMNS-1:0]                column_levels,
  // Result items.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ROWS-1:0]                   row_drive,
  output logic [kpseg_pkg::SEG_W-1:0]       segment_pattern,
  output logic [kpseg_pkg::KEY_IDX_W-1:0]   key_index,
  output logic                              key_accepted,
  // Debounce length register write port.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kpseg_pkg::TICK_W-1:0]      debounce_ticks
);

  logic [kpseg_pkg::TICK_W-1:0] debounce_reg;

  // Input stage holds one column sample until the sequencer consumes it.
  logic                         stage_valid;
  logic [COLUMNS-1:0]           stage_cols;
  logic                         advance;

  logic [ROWS-1:0]              drive_next;
  kpseg_pkg::decode_req_t       decode;
  logic [COLUMNS-1:0]           saved_cols;

  // The sequencer steps exactly when the staged item moves into the result register,
  // which happens when that register is empty or its item is being taken.
  assign advance   = stage_valid && (!out_valid || !out_stall);
  assign in_stall  = stage_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_reg <= kpseg_pkg::TICK_W'(600000);
    end else if (cfg_valid) begin
      debounce_reg <= debounce_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_cols <= column_levels;
    end
  end

  kpseg_scan #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .cols           (stage_cols),
    .debounce_ticks (debounce_reg),
    .drive_next     (drive_next),
    .decode         (decode),
    .saved_cols     (saved_cols)
  );

  // The display latch updates on the same edge as the result register, so its
  // contents are the display fields of the result being offered.
  kpseg_display #(
    .COLUMNS (COLUMNS)
  ) u_display (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .decode        (decode),
    .saved_cols    (saved_cols),
    .shown_pattern (segment_pattern),
    .shown_key     (key_index)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      row_drive    <= drive_next;
      key_accepted <= decode.accept;
    end
  end

`ifndef SYNTHESIS
  // A decoded key ends the scan, so no row is driven on that result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && key_accepted |-> row_drive == '0)
    else $error("row driven on a key decode result");

  // At most one row line is ever probed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(row_drive))
    else $error("more than one row driven");

  // The input side only stalls when a full result stage is itself stalled.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A stalled result stays offered on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");
`endif

endmodule
